[rtl/spvm_pkg.sv]
package spvm_pkg;

    localparam int STORE_DEPTH_DEF = 65536;

    // opcodes of an input word
    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_PLAY   = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_MIX    = 3'd3;
    localparam logic [2:0] OP_SETPOS = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_STEP   = 3'd1;
    localparam logic [2:0] REG_LVOL   = 3'd2;
    localparam logic [2:0] REG_RVOL   = 3'd3;
    localparam logic [2:0] REG_END    = 3'd4;
    localparam logic [2:0] REG_LSTART = 3'd5;

    // mode bit positions
    localparam int MB_16BIT  = 0;
    localparam int MB_STSRC  = 1;
    localparam int MB_STOUT  = 2;
    localparam int MB_INTERP = 3;
    localparam int MB_LOOPED = 4;

    typedef enum logic [2:0] {
        K_NONE, K_LOAD, K_PLAY, K_STOP, K_MIX, K_SETPOS
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [16:0]        address;
        logic signed [15:0] sample_value;
        logic signed [31:0] acc_left;
        logic signed [31:0] acc_right;
    } t_item;

    typedef struct packed {
        logic [4:0]  mode_bits;
        logic [21:0] step_rate;
        logic [15:0] left_volume;
        logic [15:0] right_volume;
        logic [16:0] end_index;
        logic [15:0] loop_start;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [17:0] dividend;
        logic [16:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [16:0] rem;
    } t_mod_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ELEM, ST_EMOD, ST_READ, ST_WAIT,
        ST_LERP, ST_MIX1, ST_MIX2, ST_AMOD, ST_OUT
    } t_state;

endpackage

[rtl/spvm_ram.sv]
module spvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[rtl/spvm_front.sv]
module spvm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_opcode,
    input  logic [16:0]           i_address,
    input  logic signed [15:0]    i_sample_value,
    input  logic signed [31:0]    i_acc_left,
    input  logic signed [31:0]    i_acc_right,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output spvm_pkg::t_item       o_q_item
);
    import spvm_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push, w_pop;

    // classify the opcode
    always_comb begin
        w_item.address      = i_address;
        w_item.sample_value = i_sample_value;
        w_item.acc_left     = i_acc_left;
        w_item.acc_right    = i_acc_right;
        unique case (i_opcode)
            OP_LOAD:   w_item.kind = K_LOAD;
            OP_PLAY:   w_item.kind = K_PLAY;
            OP_STOP:   w_item.kind = K_STOP;
            OP_MIX:    w_item.kind = K_MIX;
            OP_SETPOS: w_item.kind = K_SETPOS;
            default:   w_item.kind = K_NONE;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    // two-word queue toward the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end
endmodule

[rtl/spvm_mod.sv]
module spvm_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spvm_pkg::t_mod_req  i_req,
    output spvm_pkg::t_mod_rsp  o_rsp
);
    import spvm_pkg::*;

    logic [17:0] r_rem, r_dvd;
    logic [16:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [18:0] w_t, w_d;

    // one restoring remainder bit per cycle
    assign w_t = {r_rem, r_dvd[17]};
    assign w_d = (w_t >= {2'b0, r_div}) ? (w_t - {2'b0, r_div}) : w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= 5'd18;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= 18'd0;
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_cnt != 5'd0) begin
            r_rem <= w_d[17:0];
            r_dvd <= {r_dvd[16:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[16:0];
endmodule

[rtl/spvm_back.sv]
module spvm_back #(
    parameter int STORE_DEPTH = spvm_pkg::STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spvm_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  spvm_pkg::t_item    i_q_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_mix_left,
    output logic signed [31:0] o_mix_right,
    output logic               o_playing,
    output logic [16:0]        o_play_position
);
    import spvm_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    t_state r_state, n_state;
    logic [16:0] r_pos, n_pos;
    logic [15:0] r_frac, n_frac;
    logic r_act, n_act;
    logic [1:0] r_k, n_k;
    logic signed [16:0] r_e [4];
    logic signed [16:0] n_e [4];
    logic [17:0] r_idx, n_idx;
    t_item r_item, n_item;
    logic signed [33:0] r_d0, r_d1, n_d0, n_d1;
    logic signed [32:0] r_pl, r_pr, n_pl, n_pr;
    logic signed [31:0] r_rl, r_rr, n_rl, n_rr;
    logic w_load_out;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_rdata;
    t_mod_req      mod_req;
    t_mod_rsp      mod_rsp;

    // working values
    logic m16, st, so, ip, loop_ok;
    logic [1:0] last_k;
    logic [17:0] j, p2;
    logic [16:0] fsum;
    logic signed [16:0] ext, lerp0, lerp1, vl, vr, vs;
    logic signed [17:0] s2;
    logic signed [33:0] q0, q1;
    logic signed [32:0] sl, sr;

    spvm_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_item.sample_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spvm_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // next state and datapath
    always_comb begin
        m16     = i_cfg.mode_bits[MB_16BIT];
        st      = i_cfg.mode_bits[MB_STSRC];
        so      = i_cfg.mode_bits[MB_STOUT];
        ip      = i_cfg.mode_bits[MB_INTERP];
        loop_ok = i_cfg.mode_bits[MB_LOOPED] && ({1'b0, i_cfg.loop_start} < i_cfg.end_index);
        last_k  = st ? (ip ? 2'd3 : 2'd1) : (ip ? 2'd1 : 2'd0);
        j       = {1'b0, r_pos} + {16'd0, r_k};
        ext     = m16 ? {ram_rdata[15], ram_rdata} : {{9{ram_rdata[7]}}, ram_rdata[7:0]};

        // interpolate, dividing by 65536 toward zero
        q0    = (r_d0 < 0) ? ((r_d0 + 34'sd65535) >>> 16) : (r_d0 >>> 16);
        q1    = (r_d1 < 0) ? ((r_d1 + 34'sd65535) >>> 16) : (r_d1 >>> 16);
        lerp0 = r_e[0] + q0[16:0];
        lerp1 = r_e[1] + q1[16:0];
        vl    = ip ? lerp0 : r_e[0];
        vr    = st ? (ip ? lerp1 : r_e[1]) : vl;
        s2    = {vl[16], vl} + {vr[16], vr};
        s2    = (s2 < 0) ? ((s2 + 18'sd1) >>> 1) : (s2 >>> 1);
        vs    = st ? s2[16:0] : vl;

        // volume scale, 16-bit sounds divided by 256 toward zero
        sl = m16 ? ((r_pl < 0) ? ((r_pl + 33'sd255) >>> 8) : (r_pl >>> 8)) : r_pl;
        sr = m16 ? ((r_pr < 0) ? ((r_pr + 33'sd255) >>> 8) : (r_pr >>> 8)) : r_pr;

        // advance the phase
        fsum = {1'b0, r_frac} + {1'b0, i_cfg.step_rate[15:0]};
        p2   = {1'b0, r_pos} + ({12'd0, i_cfg.step_rate[21:16]} << st)
             + (fsum[16] ? (st ? 18'd2 : 18'd1) : 18'd0);

        n_state = r_state;
        n_pos   = r_pos;
        n_frac  = r_frac;
        n_act   = r_act;
        n_k     = r_k;
        n_e     = r_e;
        n_idx   = r_idx;
        n_item  = r_item;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_pl    = r_pl;
        n_pr    = r_pr;
        n_rl    = r_rl;
        n_rr    = r_rr;
        o_q_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(i_q_item.address);
        ram_re    = 1'b0;
        ram_raddr = AW'(r_idx);
        mod_req.start    = 1'b0;
        mod_req.dividend = j - {1'b0, i_cfg.end_index};
        mod_req.divisor  = i_cfg.end_index - {1'b0, i_cfg.loop_start};
        w_load_out = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_item  = i_q_item;
                    n_rl    = i_q_item.acc_left;
                    n_rr    = i_q_item.acc_right;
                    n_k     = 2'd0;
                    n_state = ST_OUT;
                    unique case (i_q_item.kind)
                        K_LOAD: begin
                            ram_we = (int'(i_q_item.address) < STORE_DEPTH);
                        end
                        K_PLAY: begin
                            n_pos  = 17'd0;
                            n_frac = 16'd0;
                            n_act  = 1'b1;
                        end
                        K_STOP: begin
                            n_pos = 17'd0;
                            n_act = 1'b0;
                        end
                        K_SETPOS: begin
                            n_pos = (i_q_item.address > i_cfg.end_index)
                                  ? i_cfg.end_index : i_q_item.address;
                            n_act = 1'b1;
                        end
                        K_MIX: begin
                            if (r_act) begin
                                n_state = ST_ELEM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ELEM: begin
                if (j < {1'b0, i_cfg.end_index}) begin
                    n_idx   = j;
                    n_state = ST_READ;
                end else if (loop_ok) begin
                    mod_req.start = 1'b1;
                    n_state       = ST_EMOD;
                end else begin
                    n_e[r_k] = 17'sd0;
                    n_k      = r_k + 2'd1;
                    n_state  = (r_k == last_k) ? ST_LERP : ST_ELEM;
                end
            end
            ST_EMOD: begin
                if (mod_rsp.done) begin
                    n_idx   = {1'b0, {1'b0, i_cfg.loop_start} + mod_rsp.rem};
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (int'(r_idx) >= STORE_DEPTH) begin
                    n_e[r_k] = 17'sd0;
                    n_k      = r_k + 2'd1;
                    n_state  = (r_k == last_k) ? ST_LERP : ST_ELEM;
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_e[r_k] = ext;
                n_k      = r_k + 2'd1;
                n_state  = (r_k == last_k) ? ST_LERP : ST_ELEM;
            end
            ST_LERP: begin
                n_d0 = ((st ? r_e[2] : r_e[1]) - r_e[0]) * $signed({1'b0, r_frac});
                n_d1 = (r_e[3] - r_e[1]) * $signed({1'b0, r_frac});
                n_state = ST_MIX1;
            end
            ST_MIX1: begin
                n_pl = (so ? vl : vs) * $signed({1'b0, i_cfg.left_volume});
                n_pr = vr * $signed({1'b0, i_cfg.right_volume});
                n_state = ST_MIX2;
            end
            ST_MIX2: begin
                n_rl   = r_item.acc_left + sl[31:0];
                n_rr   = so ? (r_item.acc_right + sr[31:0]) : r_item.acc_right;
                n_frac = fsum[15:0];
                n_state = ST_OUT;
                if (p2 >= {1'b0, i_cfg.end_index}) begin
                    if (loop_ok) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = p2 - {1'b0, i_cfg.end_index};
                        n_state          = ST_AMOD;
                    end else begin
                        n_pos = 17'd0;
                        n_act = 1'b0;
                    end
                end else begin
                    n_pos = p2[16:0];
                end
            end
            ST_AMOD: begin
                if (mod_rsp.done) begin
                    n_pos   = {1'b0, i_cfg.loop_start} + mod_rsp.rem;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!o_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= 17'd0;
            r_frac  <= 16'd0;
            r_act   <= 1'b0;
            r_k     <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_frac  <= n_frac;
            r_act   <= n_act;
            r_k     <= n_k;
            if (w_load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_idx  <= n_idx;
        r_item <= n_item;
        r_d0   <= n_d0;
        r_d1   <= n_d1;
        r_pl   <= n_pl;
        r_pr   <= n_pr;
        r_rl   <= n_rl;
        r_rr   <= n_rr;
        if (w_load_out) begin
            o_mix_left      <= r_rl;
            o_mix_right     <= r_rr;
            o_playing       <= r_act;
            o_play_position <= r_pos;
        end
    end
endmodule

[rtl/sample_playback_voice_mixer.sv]
// Control and load words go from ST_IDLE straight to ST_OUT; a mix word steps through
// ST_ELEM, ST_READ and ST_WAIT per element (1, 2 or 4 elements; one past the end with no loop
// is zeroed in ST_ELEM, one past the store in ST_READ), and each loop wrap waits on the serial
// remainder unit. Throughput is set by the single store read port and the 18-step remainder unit.
// Synchronous active-low reset clears voice state and loads register defaults;
// the sample store is not cleared and holds unknown data until written.
module sample_playback_voice_mixer #(
    parameter int STORE_DEPTH = spvm_pkg::STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic [16:0]        i_address,
    input  logic signed [15:0] i_sample_value,
    input  logic signed [31:0] i_acc_left,
    input  logic signed [31:0] i_acc_right,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_mix_left,
    output logic signed [31:0] o_mix_right,
    output logic               o_playing,
    output logic [16:0]        o_play_position,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import spvm_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_valid, q_ready;

    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode_bits    <= 5'd0;
            r_cfg.step_rate    <= 22'd65536;
            r_cfg.left_volume  <= 16'd256;
            r_cfg.right_volume <= 16'd256;
            r_cfg.end_index    <= 17'd0;
            r_cfg.loop_start   <= 16'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_MODE:   r_cfg.mode_bits    <= pwdata[4:0];
                REG_STEP:   r_cfg.step_rate    <= pwdata[21:0];
                REG_LVOL:   r_cfg.left_volume  <= pwdata[15:0];
                REG_RVOL:   r_cfg.right_volume <= pwdata[15:0];
                REG_END:    r_cfg.end_index    <= pwdata[16:0];
                REG_LSTART: r_cfg.loop_start   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:   prdata = {27'd0, r_cfg.mode_bits};
            REG_STEP:   prdata = {10'd0, r_cfg.step_rate};
            REG_LVOL:   prdata = {16'd0, r_cfg.left_volume};
            REG_RVOL:   prdata = {16'd0, r_cfg.right_volume};
            REG_END:    prdata = {15'd0, r_cfg.end_index};
            REG_LSTART: prdata = {16'd0, r_cfg.loop_start};
            default:    prdata = 32'd0;
        endcase
    end

    spvm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_sample_value (i_sample_value),
        .i_acc_left     (i_acc_left),
        .i_acc_right    (i_acc_right),
        .o_q_valid      (q_valid),
        .i_q_ready      (q_ready),
        .o_q_item       (q_item)
    );

    spvm_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .o_q_ready       (q_ready),
        .i_q_item        (q_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mix_left      (o_mix_left),
        .o_mix_right     (o_mix_right),
        .o_playing       (o_playing),
        .o_play_position (o_play_position)
    );
endmodule
